// ===== rtl/mlfq_pkg.sv =====
// Package for the multilevel feedback queue scheduler.
// Holds the sequencer state type, op and kind codes, register indexes and fixed sizes.
// No dependencies.
`timescale 1ns / 1ps

package mlfq_pkg;

  // Hardware queue levels and the level cap of this build
  localparam int unsigned HwLevels  = 3;
  localparam int unsigned NumLevels = 3;

  // Field widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RunW   = 16;
  localparam int unsigned SliceW = 8;
  localparam int unsigned LevelW = 2;
  localparam int unsigned KindW  = 2;
  localparam int unsigned EntryW = IdW + RunW;

  // Input operation codes
  localparam logic OpAdmit    = 1'b0;
  localparam logic OpDispatch = 1'b1;

  // Result kind codes
  localparam logic [KindW-1:0] KindAdmit  = 2'd0;
  localparam logic [KindW-1:0] KindReject = 2'd1;
  localparam logic [KindW-1:0] KindRun    = 2'd2;
  localparam logic [KindW-1:0] KindIdle   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgSlice0 = 2'd0;
  localparam logic [1:0] CfgSlice1 = 2'd1;
  localparam logic [1:0] CfgSlice2 = 2'd2;
  localparam logic [1:0] CfgLevels = 2'd3;

  typedef enum logic {
    SchIdle,
    SchExec
  } sched_state_e;

endpackage

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// Three-level multilevel feedback queue scheduler, top level.
// Queue entries live in one synchronous memory; uses mlfq_pkg.
//
//   channel | dir | handshake                | payload
//   --------+-----+--------------------------+----------------------------------------------
//   in      | in  | in_valid_i / in_stall_o  | op, task_id, arrival_time, run_length
//   out     | out | out_valid_o / out_stall_i| kind, served_id, served_level, start_time,
//           |     |                          | slice_length, task_done
//   cfg     | in  | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// Each item is taken in Idle, where the accept cycle issues the memory read of the queue head;
// in Exec the shared time adder and slice compare run and the tail entry is written.
// The memory read is registered, so the head entry is ready in Exec.
// The result register frees the input side: a new item is taken while a result waits,
// but its Exec step holds until the result register is free.
// Reset empties all queues, clears the time counter and loads the default slices.
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic [mlfq_pkg::IdW-1:0]             task_id_i,
  input  logic [mlfq_pkg::TimeW-1:0]           arrival_time_i,
  input  logic [mlfq_pkg::RunW-1:0]            run_length_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mlfq_pkg::KindW-1:0]           kind_o,
  output logic [mlfq_pkg::IdW-1:0]             served_id_o,
  output logic [mlfq_pkg::LevelW-1:0]          served_level_o,
  output logic [mlfq_pkg::TimeW-1:0]           start_time_o,
  output logic [mlfq_pkg::SliceW-1:0]          slice_length_o,
  output logic                                 task_done_o,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [mlfq_pkg::SliceW-1:0]          cfg_data_i
);

  localparam int unsigned MemDepth = mlfq_pkg::HwLevels * QUEUE_DEPTH;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned PtrW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW     = CntW + 1;

  localparam logic [AddrW-1:0] DepthA   = AddrW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0]  CntFull  = CntW'(QUEUE_DEPTH);
  localparam logic [SumW-1:0]  DepthS   = SumW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(QUEUE_DEPTH - 1);

  localparam int unsigned LvlCap =
      (mlfq_pkg::NumLevels < mlfq_pkg::HwLevels) ? mlfq_pkg::NumLevels : mlfq_pkg::HwLevels;

  mlfq_pkg::sched_state_e state_q, state_d;

  // Configuration
  logic [mlfq_pkg::SliceW-1:0] slice_q [mlfq_pkg::HwLevels];
  logic [1:0]                  levels_q;

  // Queue bookkeeping
  logic [PtrW-1:0]             head_q  [mlfq_pkg::HwLevels];
  logic [PtrW-1:0]             head_d  [mlfq_pkg::HwLevels];
  logic [CntW-1:0]             count_q [mlfq_pkg::HwLevels];
  logic [CntW-1:0]             count_d [mlfq_pkg::HwLevels];
  logic [PtrW-1:0]             tail_pos [mlfq_pkg::HwLevels];
  logic [mlfq_pkg::TimeW-1:0]  time_q, time_d;

  // Entry memory
  logic [mlfq_pkg::EntryW-1:0] mem_q [MemDepth];
  logic [mlfq_pkg::EntryW-1:0] rd_q;
  logic                        rd_en, wr_en;
  logic [AddrW-1:0]            rd_addr, wr_addr;
  logic [mlfq_pkg::EntryW-1:0] wr_data;

  // Held item
  logic                        op_q;
  logic [mlfq_pkg::IdW-1:0]    id_q;
  logic [mlfq_pkg::TimeW-1:0]  arr_q;
  logic [mlfq_pkg::RunW-1:0]   run_q;

  // Result register
  logic                         out_valid_q, out_valid_d;
  logic [mlfq_pkg::KindW-1:0]   kind_q, kind_d;
  logic [mlfq_pkg::IdW-1:0]     sid_q, sid_d;
  logic [mlfq_pkg::LevelW-1:0]  slvl_q, slvl_d;
  logic [mlfq_pkg::TimeW-1:0]   start_q, start_d;
  logic [mlfq_pkg::SliceW-1:0]  slen_q, slen_d;
  logic                         done_q, done_d;

  logic                         in_acc, fire;
  logic                         all_empty;
  logic [mlfq_pkg::LevelW-1:0]  lvl_sel, target, used;
  logic [mlfq_pkg::SliceW-1:0]  slice_eff, run_slice, add_val;
  logic [mlfq_pkg::RunW-1:0]    rem_old, rem_new;
  logic [mlfq_pkg::TimeW-1:0]   time_sum;

  assign in_stall_o = (state_q != mlfq_pkg::SchIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fire       = (state_q == mlfq_pkg::SchExec) && (!out_valid_q || !out_stall_i);

  // Level selection and queue status
  always_comb begin
    all_empty = 1'b1;
    for (int l = 0; l < mlfq_pkg::HwLevels; l++) begin
      if (count_q[l] != '0) all_empty = 1'b0;
    end
    if (count_q[0] != '0) lvl_sel = 2'd0;
    else if (count_q[1] != '0) lvl_sel = 2'd1;
    else lvl_sel = 2'd2;
  end

  // Tail position of each queue
  always_comb begin
    logic [SumW-1:0] sum;
    for (int l = 0; l < mlfq_pkg::HwLevels; l++) begin
      sum = SumW'(head_q[l]) + SumW'(count_q[l]);
      if (sum >= DepthS) sum = sum - DepthS;
      tail_pos[l] = sum[PtrW-1:0];
    end
  end

  // Levels in use: zero acts as one, capped by the build
  always_comb begin
    used = (levels_q == 2'd0) ? 2'd1 : levels_q;
    if (32'(used) > LvlCap) used = mlfq_pkg::LevelW'(LvlCap);
  end

  // Shared slice compare, time adder and demotion target
  always_comb begin
    slice_eff = (slice_q[lvl_sel] == '0) ? 8'd1 : slice_q[lvl_sel];
    rem_old   = rd_q[mlfq_pkg::RunW-1:0];
    run_slice = (16'(slice_eff) < rem_old) ? slice_eff : rem_old[mlfq_pkg::SliceW-1:0];
    rem_new   = rem_old - 16'(run_slice);
    add_val   = (op_q == mlfq_pkg::OpDispatch && !all_empty) ? run_slice : 8'd1;
    time_sum  = time_q + 32'(add_val);
    if (3'(lvl_sel) + 3'd1 < 3'(used)) target = lvl_sel + 2'd1;
    else target = lvl_sel;
    if (count_q[target] >= CntFull) target = lvl_sel;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlfq_pkg::SchIdle: if (in_acc) state_d = mlfq_pkg::SchExec;
      mlfq_pkg::SchExec: if (fire) state_d = mlfq_pkg::SchIdle;
      default:           state_d = mlfq_pkg::SchIdle;
    endcase
  end

  // Datapath and result
  always_comb begin
    rd_en       = in_acc && (op_i == mlfq_pkg::OpDispatch);
    rd_addr     = AddrW'(lvl_sel) * DepthA + AddrW'(head_q[lvl_sel]);
    wr_en       = 1'b0;
    wr_addr     = AddrW'(target) * DepthA + AddrW'(tail_pos[target]);
    wr_data     = {rd_q[mlfq_pkg::EntryW-1:mlfq_pkg::RunW], rem_new};
    head_d      = head_q;
    count_d     = count_q;
    time_d      = time_q;
    kind_d      = kind_q;
    sid_d       = sid_q;
    slvl_d      = slvl_q;
    start_d     = start_q;
    slen_d      = slen_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (fire) begin
      out_valid_d = 1'b1;
      sid_d       = id_q;
      slvl_d      = '0;
      slen_d      = '0;
      done_d      = 1'b0;
      start_d     = time_q;
      if (op_q == mlfq_pkg::OpAdmit) begin
        if (count_q[0] >= CntFull) begin
          kind_d = mlfq_pkg::KindReject;
        end else begin
          kind_d     = mlfq_pkg::KindAdmit;
          wr_en      = 1'b1;
          wr_addr    = AddrW'(tail_pos[0]);
          wr_data    = {id_q, run_q};
          count_d[0] = count_q[0] + 1'b1;
          if (all_empty && arr_q > time_q) begin
            time_d  = arr_q;
            start_d = arr_q;
          end
        end
      end else if (all_empty) begin
        kind_d = mlfq_pkg::KindIdle;
        sid_d  = '0;
        time_d = time_sum;
      end else begin
        kind_d           = mlfq_pkg::KindRun;
        sid_d            = rd_q[mlfq_pkg::EntryW-1:mlfq_pkg::RunW];
        slvl_d           = lvl_sel;
        slen_d           = run_slice;
        time_d           = time_sum;
        head_d[lvl_sel]  = (head_q[lvl_sel] == PtrLast) ? '0 : head_q[lvl_sel] + 1'b1;
        count_d[lvl_sel] = count_q[lvl_sel] - 1'b1;
        if (rem_new == '0) begin
          done_d = 1'b1;
        end else begin
          // Demote, or requeue at own tail; that tail equals the pre-pop tail
          wr_en           = 1'b1;
          count_d[target] = count_d[target] + 1'b1;
        end
      end
    end
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // Held item and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= op_i;
      id_q  <= task_id_i;
      arr_q <= arrival_time_i;
      run_q <= run_length_i;
    end
    kind_q  <= kind_d;
    sid_q   <= sid_d;
    slvl_q  <= slvl_d;
    start_q <= start_d;
    slen_q  <= slen_d;
    done_q  <= done_d;
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlfq_pkg::SchIdle;
      out_valid_q <= 1'b0;
      time_q      <= '0;
      slice_q[0]  <= 8'd2;
      slice_q[1]  <= 8'd4;
      slice_q[2]  <= 8'd8;
      levels_q    <= 2'd3;
      for (int l = 0; l < mlfq_pkg::HwLevels; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      time_q      <= time_d;
      head_q      <= head_d;
      count_q     <= count_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mlfq_pkg::CfgSlice0: slice_q[0] <= cfg_data_i;
          mlfq_pkg::CfgSlice1: slice_q[1] <= cfg_data_i;
          mlfq_pkg::CfgSlice2: slice_q[2] <= cfg_data_i;
          mlfq_pkg::CfgLevels: levels_q   <= cfg_data_i[1:0];
          default:             levels_q   <= levels_q;
        endcase
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign served_id_o    = sid_q;
  assign served_level_o = slvl_q;
  assign start_time_o   = start_q;
  assign slice_length_o = slen_q;
  assign task_done_o    = done_q;

endmodule

// ===== sim/mlfq_checker.sv =====
// Scoreboard for the multilevel feedback queue scheduler testbench.
// Tracks register writes and accepted items, predicts every result and compares it.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_checker
  import mlfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               op_i,
  input  logic [IdW-1:0]     task_id_i,
  input  logic [TimeW-1:0]   arrival_time_i,
  input  logic [RunW-1:0]    run_length_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic [IdW-1:0]     served_id_i,
  input  logic [LevelW-1:0]  served_level_i,
  input  logic [TimeW-1:0]   start_time_i,
  input  logic [SliceW-1:0]  slice_length_i,
  input  logic               task_done_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [SliceW-1:0]  cfg_data_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        pending_count_o
);

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IdW-1:0]    id;
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  start;
    logic [SliceW-1:0] length;
    logic              done;
  } slice_report_t;

  localparam logic [SliceW-1:0] ResetSlice [HwLevels] = '{8'd2, 8'd4, 8'd8};
  localparam logic [1:0]        ResetLevels = 2'd3;

  logic [EntryW-1:0] ready_q   [HwLevels][QUEUE_DEPTH];
  int unsigned       q_head    [HwLevels];
  int unsigned       q_count   [HwLevels];
  logic [TimeW-1:0]  now_time;
  logic [SliceW-1:0] slice_len [HwLevels];
  logic [1:0]        levels_cfg;
  slice_report_t     awaited_reports [$];

  function automatic int unsigned active_levels();
    int unsigned n;
    n = levels_cfg;
    if (n == 0) n = 1;
    if (n > HwLevels) n = HwLevels;
    if (n > NumLevels) n = NumLevels;
    return n;
  endfunction

  task automatic enqueue(input int unsigned lvl, input logic [IdW-1:0] id,
                         input logic [RunW-1:0] rem);
    int unsigned pos;
    pos = (q_head[lvl] + q_count[lvl]) % QUEUE_DEPTH;
    ready_q[lvl][pos] = {id, rem};
    q_count[lvl]++;
  endtask

  task automatic schedule_item(input logic op, input logic [IdW-1:0] id,
                               input logic [TimeW-1:0] arrival, input logic [RunW-1:0] run,
                               output slice_report_t rep);
    bit                queues_empty;
    int unsigned       lvl;
    int unsigned       target;
    logic [EntryW-1:0] head_entry;
    logic [RunW-1:0]   remaining;
    logic [RunW-1:0]   grant;
    queues_empty = 1'b1;
    for (int l = 0; l < HwLevels; l++) begin
      if (q_count[l] != 0) queues_empty = 1'b0;
    end
    rep = '0;
    if (op == OpAdmit) begin
      rep.id = id;
      if (q_count[0] >= QUEUE_DEPTH) begin
        rep.kind = KindReject;
      end else begin
        // jump the clock forward only when nothing is waiting
        if (queues_empty && arrival > now_time) now_time = arrival;
        enqueue(0, id, run);
        rep.kind = KindAdmit;
      end
      rep.start = now_time;
    end else if (queues_empty) begin
      rep.kind  = KindIdle;
      rep.start = now_time;
      now_time  = now_time + 1'b1;
    end else begin
      lvl = 0;
      while (q_count[lvl] == 0) lvl++;
      head_entry  = ready_q[lvl][q_head[lvl]];
      q_head[lvl] = (q_head[lvl] + 1) % QUEUE_DEPTH;
      q_count[lvl]--;
      remaining = head_entry[RunW-1:0];
      grant     = (slice_len[lvl] == '0) ? RunW'(1) : RunW'(slice_len[lvl]);
      if (remaining < grant) grant = remaining;
      remaining  = remaining - grant;
      rep.kind   = KindRun;
      rep.id     = head_entry[EntryW-1:RunW];
      rep.level  = LevelW'(lvl);
      rep.start  = now_time;
      rep.length = grant[SliceW-1:0];
      now_time   = now_time + TimeW'(grant);
      if (remaining == '0) begin
        rep.done = 1'b1;
      end else begin
        // demote, but stay put past the last level in use or when the next one is full
        target = (lvl + 1 < active_levels()) ? lvl + 1 : lvl;
        if (q_count[target] >= QUEUE_DEPTH) target = lvl;
        enqueue(target, rep.id, remaining);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [TimeW-1:0] expected,
                             input logic [TimeW-1:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slice_report_t want;
    if (!rst_ni) begin
      for (int l = 0; l < HwLevels; l++) begin
        q_head[l]    = 0;
        q_count[l]   = 0;
        slice_len[l] = ResetSlice[l];
      end
      now_time   = '0;
      levels_cfg = ResetLevels;
      awaited_reports.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLevels) levels_cfg = cfg_data_i[1:0];
        else slice_len[cfg_idx_i] = cfg_data_i;
      end
      // results never leave on the edge that takes their item, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (awaited_reports.size() == 0) begin
          $error("result with no item outstanding: kind %0d id %0h", kind_i, served_id_i);
          mismatch_count_o++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("kind", want.kind, kind_i);
          check_field("served_id", want.id, served_id_i);
          check_field("served_level", want.level, served_level_i);
          check_field("start_time", want.start, start_time_i);
          check_field("slice_length", want.length, slice_length_i);
          check_field("task_done", want.done, task_done_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        schedule_item(op_i, task_id_i, arrival_time_i, run_length_i, want);
        awaited_reports.push_back(want);
      end
    end
    pending_count_o = awaited_reports.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the scheduler testbench: clock, reset, stimulus, watchdog and verdict.
// Instantiates multilevel_feedback_queue_scheduler as u_top beside mlfq_checker.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

module testbench;
  import mlfq_pkg::*;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned SendIdle [4] = '{0, 57, 0, 22};
  localparam int unsigned RecvStall[4] = '{0, 0, 57, 22};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              op;
  logic [IdW-1:0]    task_id;
  logic [TimeW-1:0]  arrival;
  logic [RunW-1:0]   run_len;
  logic              out_valid;
  logic              out_stall;
  logic [KindW-1:0]  kind;
  logic [IdW-1:0]    served_id;
  logic [LevelW-1:0] served_level;
  logic [TimeW-1:0]  start_time;
  logic [SliceW-1:0] slice_length;
  logic              task_done;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [SliceW-1:0] cfg_data;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned idle_mode;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;
  int unsigned pending_count;

  multilevel_feedback_queue_scheduler #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .task_id_i      (task_id),
    .arrival_time_i (arrival),
    .run_length_i   (run_len),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .served_id_o    (served_id),
    .served_level_o (served_level),
    .start_time_o   (start_time),
    .slice_length_o (slice_length),
    .task_done_o    (task_done),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  mlfq_checker #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .op_i             (op),
    .task_id_i        (task_id),
    .arrival_time_i   (arrival),
    .run_length_i     (run_len),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .kind_i           (kind),
    .served_id_i      (served_id),
    .served_level_i   (served_level),
    .start_time_i     (start_time),
    .slice_length_i   (slice_length),
    .task_done_i      (task_done),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // end the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // call and return at a falling edge
  task automatic send_item(input logic item_op, input logic [IdW-1:0] id,
                           input logic [TimeW-1:0] arr, input logic [RunW-1:0] run);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= item_op;
    task_id  <= id;
    arrival  <= arr;
    run_len  <= run;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_dispatch();
    send_item(OpDispatch, IdW'($urandom), $urandom, RunW'($urandom));
  endtask

  task automatic wait_settled();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idle_mode(input int unsigned mode);
    send_idle_pct = SendIdle[mode];
    stall_pct     = RecvStall[mode];
  endtask

  // only while nothing is in flight; upper bits of the level word are don't-care
  task automatic apply_settings(input logic [SliceW-1:0] s0, input logic [SliceW-1:0] s1,
                                input logic [SliceW-1:0] s2, input logic [1:0] lv);
    logic [SliceW-1:0] lv_word;
    lv_word  = SliceW'($urandom_range(63) << 2) | SliceW'(lv);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgSlice0;
    cfg_data <= s0;
    @(negedge clk);
    cfg_idx  <= CfgSlice1;
    cfg_data <= s1;
    @(negedge clk);
    cfg_idx  <= CfgSlice2;
    cfg_data <= s2;
    @(negedge clk);
    cfg_idx  <= CfgLevels;
    cfg_data <= lv_word;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_item(input int unsigned admit_pct);
    logic [RunW-1:0]  run;
    logic [TimeW-1:0] arr;
    int unsigned      pick;
    pick = $urandom_range(99);
    // mostly short jobs so queues drain and empty-queue cases keep coming up
    if (pick < 75) run = RunW'($urandom_range(24));
    else if (pick < 97) run = RunW'($urandom_range(400, 25));
    else run = RunW'($urandom_range(1500, 401));
    arr = ($urandom_range(1) == 1) ? $urandom : $urandom_range(4096);
    if ($urandom_range(99) < admit_pct) send_item(OpAdmit, IdW'($urandom), arr, run);
    else send_dispatch();
  endtask

  task automatic run_phase(input int unsigned admit_pct);
    for (int i = 0; i < PhaseItems; i++) begin
      if (i % 30 == 0) begin
        set_idle_mode(idle_mode % 4);
        idle_mode++;
      end
      if ($urandom_range(99) == 0) wait_settled();
      random_item(admit_pct);
    end
  endtask

  initial begin
    in_valid      = 1'b0;
    op            = OpAdmit;
    task_id       = '0;
    arrival       = '0;
    run_len       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgSlice0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    idle_mode     = 0;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part on the reset slices 2/4/8 with three levels
    send_dispatch();                                   // idle tick at time zero
    send_item(OpAdmit, 8'hFF, 32'hFFFF_FFF0, 16'd30);  // empty queues: clock jumps
    send_item(OpAdmit, 8'h00, 32'h0000_0000, 16'd0);   // zero run length
    send_item(OpAdmit, 8'hA5, 32'hFFFF_FFFF, 16'd1);   // queues busy: no jump
    repeat (6) send_dispatch();                        // walk down all levels, clock wraps
    send_item(OpAdmit, 8'h5A, 32'd100, 16'd3);
    repeat (4) send_dispatch();                        // level 0 served ahead of level 2
    send_item(OpAdmit, 8'h11, 32'd3, 16'd5);           // arrival behind the clock
    send_item(OpAdmit, 8'h22, 32'd7, 16'd4);
    repeat (5) send_dispatch();

    // one maximum-length task, plain round robin with full slices, then idle ticks
    wait_settled();
    apply_settings(8'd255, 8'd255, 8'd255, 2'd1);
    set_idle_mode(3);
    send_item(OpAdmit, 8'h3C, $urandom, 16'hFFFF);
    repeat (262) send_dispatch();

    // fill level 0, demote all of it into a full level 1, then overflow both
    wait_settled();
    apply_settings(8'd1, 8'd255, 8'd255, 2'd2);
    set_idle_mode(1);
    repeat (64) send_item(OpAdmit, IdW'($urandom), $urandom, RunW'($urandom_range(40, 2)));
    set_idle_mode(2);
    repeat (64) send_dispatch();
    repeat (4) send_item(OpAdmit, IdW'($urandom), $urandom, RunW'($urandom_range(40, 2)));
    repeat (4) send_dispatch();
    set_idle_mode(0);
    repeat (70) send_item(OpAdmit, IdW'($urandom), $urandom, RunW'($urandom_range(40, 2)));

    // random phases; lowering the level count strands nothing
    wait_settled();
    apply_settings(8'd1, 8'd1, 8'd1, 2'd1);
    run_phase(50);
    wait_settled();
    apply_settings(8'd255, 8'd255, 8'd255, 2'd3);
    run_phase(30);
    wait_settled();
    apply_settings(8'd0, 8'd0, 8'd0, 2'd0);
    run_phase(55);
    wait_settled();
    apply_settings(8'd2, 8'd4, 8'd8, 2'd3);
    run_phase(60);
    wait_settled();
    apply_settings(SliceW'($urandom_range(255, 1)), SliceW'($urandom_range(255, 1)),
                   SliceW'($urandom_range(255, 1)), 2'd2);
    run_phase(50);
    wait_settled();
    apply_settings(8'd255, 8'd1, 8'd3, 2'd3);
    run_phase(70);
    wait_settled();
    apply_settings(SliceW'($urandom), SliceW'($urandom), SliceW'($urandom),
                   2'($urandom_range(3)));
    run_phase(40);
    wait_settled();
    apply_settings(8'd200, 8'd255, 8'd255, 2'd1);
    run_phase(20);

    wait_settled();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
